>>> rtl/core/idbw_pkg.sv
// Shared types and constants for the I2C display byte writer.
package idbw_pkg;

   // Item kinds on the request channel
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   // Classified item as it sits in the front queue
   typedef struct packed {
      op_type     op;
      logic [7:0] payload;
      logic       is_data;
   } item_type;

   // Queue head handed from front to engine
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   // Result beat
   typedef struct packed {
      logic clock_line;
      logic data_line;
      logic busy_res;
      logic last_step;
      logic rejected;
   } rsp_type;

   // Transaction segments
   typedef enum logic [1:0] {
      SEG_START = 2'd0,
      SEG_BYTE  = 2'd1,
      SEG_STOP  = 2'd2
   } seg_type;

   // Bit-cell phases inside a byte
   typedef enum logic [1:0] {
      PH_DATA  = 2'd0,
      PH_HIGH  = 2'd1,
      PH_LOW   = 2'd2
   } phase_type;

   // Byte slots
   typedef enum logic [1:0] {
      BYTE_ADDR    = 2'd0,
      BYTE_CONTROL = 2'd1,
      BYTE_PAYLOAD = 2'd2
   } slot_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] ADDR_RESET   = 8'd120;
   localparam logic [7:0] CTRL_COMMAND = 8'h00;
   localparam logic [7:0] CTRL_DATA    = 8'h40;

   // Sub-step codes
   localparam logic [4:0] START_SCL_HIGH = 5'd0;
   localparam logic [4:0] START_SDA_HIGH = 5'd1;
   localparam logic [4:0] START_SDA_LOW  = 5'd2;
   localparam logic [4:0] START_SCL_LOW  = 5'd3;
   localparam logic [4:0] BYTE_LEAD_LOW  = 5'd0;
   localparam logic [4:0] BYTE_BITS_END  = 5'd24;
   localparam logic [4:0] BYTE_ACK_HIGH  = 5'd25;
   localparam logic [4:0] BYTE_ACK_LOW   = 5'd26;
   localparam logic [4:0] STOP_SCL_HIGH  = 5'd0;
   localparam logic [4:0] STOP_SDA_LOW   = 5'd1;
   localparam logic [4:0] STOP_SDA_HIGH  = 5'd2;

endpackage

>>> rtl/core/idbw_front.sv
// Front end: accepts request beats, classifies them and queues them.
module idbw_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_operation,
   input  logic [7:0]        req_payload,
   input  logic              req_is_data,
   output idbw_pkg::head_type head,
   input  logic              head_pop
);

   idbw_pkg::item_type                    queue_ff [idbw_pkg::QUEUE_DEPTH];
   logic [idbw_pkg::QUEUE_AW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [idbw_pkg::QUEUE_AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [idbw_pkg::QUEUE_AW:0]           count_ff, count_in;
   idbw_pkg::item_type                    item_new;
   logic                                  push;
   logic                                  pop;

   // classify the incoming beat
   always_comb begin
      item_new.op      = idbw_pkg::op_type'(req_operation);
      item_new.payload = req_payload;
      item_new.is_data = req_is_data;
   end

   assign req_ready = (count_ff != (idbw_pkg::QUEUE_AW+1)'(idbw_pkg::QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign pop       = head_pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.item  = queue_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

>>> rtl/core/idbw_engine.sv
// Back end: pin-step sequencer, address register and result register.
module idbw_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [7:0]         csr_write_data,
   input  idbw_pkg::head_type head,
   output logic               head_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output idbw_pkg::rsp_type  rsp
);

   logic [7:0]          addr_ff;
   logic                busy_ff, busy_in;
   logic [7:0]          held_payload_ff, held_payload_in;
   logic                held_kind_ff, held_kind_in;
   logic                clock_level_ff, clock_level_in;
   logic                data_level_ff, data_level_in;
   idbw_pkg::seg_type   seg_ff, seg_in;
   logic [4:0]          sub_ff, sub_in;
   idbw_pkg::slot_type  slot_ff, slot_in;
   logic [2:0]          bit_ff, bit_in;
   idbw_pkg::phase_type phase_ff, phase_in;
   logic                last_in;
   logic                rejected_in;
   logic [7:0]          cur_byte;
   logic                rsp_valid_ff, rsp_valid_in;
   idbw_pkg::rsp_type   rsp_ff;
   idbw_pkg::rsp_type   rsp_in;

   // address register
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= idbw_pkg::ADDR_RESET;
      end else if (csr_write_enable) begin
         addr_ff <= csr_write_data;
      end
   end

   // take a beat when the result register is free or draining
   assign head_pop = head.valid && (!rsp_valid_ff || rsp_ready);

   // byte currently on the wire
   always_comb begin
      case (slot_ff)
         idbw_pkg::BYTE_ADDR:    cur_byte = addr_ff;
         idbw_pkg::BYTE_CONTROL: cur_byte = held_kind_ff ? idbw_pkg::CTRL_DATA
                                                         : idbw_pkg::CTRL_COMMAND;
         default:                cur_byte = held_payload_ff;
      endcase
   end

   // sequencer next state
   always_comb begin
      busy_in         = busy_ff;
      held_payload_in = held_payload_ff;
      held_kind_in    = held_kind_ff;
      clock_level_in  = clock_level_ff;
      data_level_in   = data_level_ff;
      seg_in          = seg_ff;
      sub_in          = sub_ff;
      slot_in         = slot_ff;
      bit_in          = bit_ff;
      phase_in        = phase_ff;
      last_in         = 1'b0;
      rejected_in     = 1'b0;

      if (head_pop) begin
         if (head.item.op == idbw_pkg::OP_LOAD) begin
            if (busy_ff) begin
               rejected_in = 1'b1;
            end else begin
               held_payload_in = head.item.payload;
               held_kind_in    = head.item.is_data;
               busy_in         = 1'b1;
               seg_in          = idbw_pkg::SEG_START;
               sub_in          = idbw_pkg::START_SCL_HIGH;
               slot_in         = idbw_pkg::BYTE_ADDR;
            end
         end else if (busy_ff) begin
            unique case (seg_ff)
               idbw_pkg::SEG_START: begin
                  case (sub_ff)
                     idbw_pkg::START_SCL_HIGH: clock_level_in = 1'b1;
                     idbw_pkg::START_SDA_HIGH: data_level_in  = 1'b1;
                     idbw_pkg::START_SDA_LOW:  data_level_in  = 1'b0;
                     default:                  clock_level_in = 1'b0;
                  endcase
                  if (sub_ff == idbw_pkg::START_SCL_LOW) begin
                     seg_in  = idbw_pkg::SEG_BYTE;
                     sub_in  = idbw_pkg::BYTE_LEAD_LOW;
                     slot_in = idbw_pkg::BYTE_ADDR;
                  end else begin
                     sub_in = sub_ff + 5'd1;
                  end
               end
               idbw_pkg::SEG_BYTE: begin
                  sub_in = sub_ff + 5'd1;
                  if (sub_ff == idbw_pkg::BYTE_LEAD_LOW) begin
                     clock_level_in = 1'b0;
                     bit_in         = '0;
                     phase_in       = idbw_pkg::PH_DATA;
                  end else if (sub_ff <= idbw_pkg::BYTE_BITS_END) begin
                     unique case (phase_ff)
                        idbw_pkg::PH_DATA: begin
                           // MSB first: bit 7 - k
                           data_level_in = cur_byte[~bit_ff];
                           phase_in      = idbw_pkg::PH_HIGH;
                        end
                        idbw_pkg::PH_HIGH: begin
                           clock_level_in = 1'b1;
                           phase_in       = idbw_pkg::PH_LOW;
                        end
                        default: begin
                           clock_level_in = 1'b0;
                           phase_in       = idbw_pkg::PH_DATA;
                           bit_in         = bit_ff + 3'd1;
                        end
                     endcase
                  end else if (sub_ff == idbw_pkg::BYTE_ACK_HIGH) begin
                     clock_level_in = 1'b1;
                  end else begin
                     // ack clock low closes the byte
                     clock_level_in = 1'b0;
                     sub_in         = idbw_pkg::BYTE_LEAD_LOW;
                     if (slot_ff == idbw_pkg::BYTE_PAYLOAD) begin
                        seg_in = idbw_pkg::SEG_STOP;
                        sub_in = idbw_pkg::STOP_SCL_HIGH;
                     end else begin
                        slot_in = idbw_pkg::slot_type'(slot_ff + 2'd1);
                     end
                  end
               end
               default: begin
                  sub_in = sub_ff + 5'd1;
                  case (sub_ff)
                     idbw_pkg::STOP_SCL_HIGH: clock_level_in = 1'b1;
                     idbw_pkg::STOP_SDA_LOW:  data_level_in  = 1'b0;
                     default: begin
                        data_level_in = 1'b1;
                        busy_in       = 1'b0;
                        last_in       = 1'b1;
                        seg_in        = idbw_pkg::SEG_START;
                        sub_in        = idbw_pkg::START_SCL_HIGH;
                     end
                  endcase
               end
            endcase
         end
      end
   end

   // result register
   always_comb begin
      rsp_in.clock_line = clock_level_in;
      rsp_in.data_line  = data_level_in;
      rsp_in.busy_res   = busy_in;
      rsp_in.last_step  = last_in;
      rsp_in.rejected   = rejected_in;
      rsp_valid_in      = rsp_valid_ff;
      if (head_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         held_payload_ff <= '0;
         held_kind_ff    <= 1'b0;
         clock_level_ff  <= 1'b1;
         data_level_ff   <= 1'b1;
         seg_ff          <= idbw_pkg::SEG_START;
         sub_ff          <= '0;
         slot_ff         <= idbw_pkg::BYTE_ADDR;
         bit_ff          <= '0;
         phase_ff        <= idbw_pkg::PH_DATA;
         rsp_valid_ff    <= 1'b0;
      end else begin
         busy_ff         <= busy_in;
         held_payload_ff <= held_payload_in;
         held_kind_ff    <= held_kind_in;
         clock_level_ff  <= clock_level_in;
         data_level_ff   <= data_level_in;
         seg_ff          <= seg_in;
         sub_ff          <= sub_in;
         slot_ff         <= slot_in;
         bit_ff          <= bit_in;
         phase_ff        <= phase_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      if (head_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> rtl/core/i2c_display_byte_writer_unit.sv
// Top level of the write-only I2C display byte writer.
//
// Request channel (req_*): each beat is a load (operation 0) or a tick
// (operation 1). A load taken while idle latches payload and is_data and
// starts an 88-step transaction; a load while busy is answered with
// rsp_rejected. Each tick while busy drives one pin step: start, address byte,
// control byte (0x00 command, 0x40 data), payload byte, stop.
// Response channel (rsp_*): exactly one beat per request beat, in order,
// carrying the SCL/SDA levels after the step, busy, last step and reject.
// csr_write_enable/csr_write_data set the address byte (reset 120); write
// it only while no beats are in flight.
// An accepted beat passes through the queue and then the result register
// before its response appears on rsp.
// Throughput: one beat per cycle while the receiver takes responses, set by the single-step sequencer.
// A two-entry queue sits between front end and sequencer; when the
// receiver stalls, the result register holds and the queue fills, then
// req_ready drops. Reset empties both and releases SCL and SDA high.
module i2c_display_byte_writer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_operation,
   input  logic [7:0] req_payload,
   input  logic       req_is_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_clock_line,
   output logic       rsp_data_line,
   output logic       rsp_busy_res,
   output logic       rsp_last_step,
   output logic       rsp_rejected
);

   idbw_pkg::head_type head;
   logic               head_pop;
   idbw_pkg::rsp_type  rsp;

   idbw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_payload   (req_payload),
      .req_is_data   (req_is_data),
      .head          (head),
      .head_pop      (head_pop)
   );

   idbw_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .head             (head),
      .head_pop         (head_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp              (rsp)
   );

   assign rsp_clock_line = rsp.clock_line;
   assign rsp_data_line  = rsp.data_line;
   assign rsp_busy_res   = rsp.busy_res;
   assign rsp_last_step  = rsp.last_step;
   assign rsp_rejected   = rsp.rejected;

   // final stop step leaves the bus idle with both lines high
   a_last_releases_bus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_step |->
         !rsp_busy_res && rsp_clock_line && rsp_data_line)
      else $error("last step without idle bus");

   // a rejected load only happens during a transaction
   a_reject_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_busy_res && !rsp_last_step)
      else $error("reject outside a transaction");

   // nothing leaves the block right after reset
   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response beat right after reset");

   // the engine only pops when the queue has a beat
   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head.valid)
      else $error("pop from empty queue");

endmodule
